// ----- hw/rtl/slp_pkg.sv -----
// Shared types, constants and helper functions for the louver stepper positioner.
package slp_pkg;

  localparam int POSITION_BITS_DEFAULT = 12;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_TARGET    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MID_TARGET    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SWING_TOP     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_TRAVEL   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_PERIOD   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_PERIOD   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REVERSE_PAUSE = 3'd6;

  localparam logic [11:0] LOW_TARGET_RESET    = 12'd268;
  localparam logic [11:0] MID_TARGET_RESET    = 12'd723;
  localparam logic [11:0] SWING_TOP_RESET     = 12'd910;
  localparam logic [11:0] FULL_TRAVEL_RESET   = 12'd1308;
  localparam logic [7:0]  FAST_PERIOD_RESET   = 8'd4;
  localparam logic [7:0]  SLOW_PERIOD_RESET   = 8'd30;
  localparam logic [15:0] REVERSE_PAUSE_RESET = 16'd300;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  localparam logic [3:0] MODE_STOP      = 4'd0;
  localparam logic [3:0] MODE_RECALL    = 4'd1;
  localparam logic [3:0] MODE_CLOSE     = 4'd2;
  localparam logic [3:0] MODE_INIT      = 4'd3;
  localparam logic [3:0] MODE_HORIZ     = 4'd4;
  localparam logic [3:0] MODE_UPPER     = 4'd5;
  localparam logic [3:0] MODE_LOWER     = 4'd6;
  localparam logic [3:0] MODE_SWING     = 4'd7;
  localparam logic [3:0] MODE_CENTRAL   = 4'd8;
  localparam logic [3:0] MODE_COILS_OFF = 4'd9;

  typedef struct packed {
    logic [11:0] low_target;
    logic [11:0] mid_target;
    logic [11:0] swing_top;
    logic [11:0] full_travel;
    logic [7:0]  fast_period;
    logic [7:0]  slow_period;
    logic [15:0] reverse_pause;
  } slp_cfg_t;

  typedef struct packed {
    logic [3:0] coil_pattern;
    logic       motor_on;
    logic       moving_up;
    logic       stepped;
    logic       arrived;
    logic       pausing;
  } slp_status_t;

  function automatic logic [3:0] coil_of(input logic [2:0] phase);
    logic [3:0] pattern;
    case (phase)
      3'd0: pattern = 4'h1;
      3'd1: pattern = 4'h3;
      3'd2: pattern = 4'h2;
      3'd3: pattern = 4'h6;
      3'd4: pattern = 4'h4;
      3'd5: pattern = 4'hc;
      3'd6: pattern = 4'h8;
      3'd7: pattern = 4'h9;
      default: pattern = 4'h0;
    endcase
    return pattern;
  endfunction

  function automatic logic [7:0] ramp(input logic [7:0] period, input logic [7:0] slow,
                                      input logic [7:0] cruise, input logic braking);
    logic [7:0] result;
    result = period;
    if (braking) begin
      if (period < slow) begin
        result = period + 8'd1;
      end
    end else if (period > cruise) begin
      result = period - 8'd1;
    end
    return result;
  endfunction

endpackage

// ----- hw/rtl/slp_engine.sv -----
// Motion state of the positioner and its update for one request.
module slp_engine #(
  parameter int POSITION_BITS = slp_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  logic                     operation,
  input  logic [3:0]               mode,
  input  slp_pkg::slp_cfg_t        cfg,
  output logic [POSITION_BITS-1:0] position,
  output slp_pkg::slp_status_t     status
);

  logic [POSITION_BITS-1:0] position_now, position_now_next;
  logic [POSITION_BITS-1:0] target_position, target_position_next;
  logic [POSITION_BITS-1:0] upper_limit, upper_limit_next;
  logic [POSITION_BITS-1:0] lower_limit, lower_limit_next;
  logic [POSITION_BITS-1:0] saved_position, saved_position_next;
  logic [15:0]              upper_brake_point, upper_brake_point_next;
  logic [15:0]              lower_brake_point, lower_brake_point_next;
  logic                     direction_up, direction_up_next;
  logic                     enabled, enabled_next;
  logic                     coils_released, coils_released_next;
  logic [7:0]               step_period, step_period_next;
  logic [7:0]               cruise_period, cruise_period_next;
  logic [7:0]               tick_counter, tick_counter_next;
  logic [15:0]              pause_counter, pause_counter_next;
  logic [2:0]               phase_index, phase_index_next;
  logic [3:0]               angle_mode, angle_mode_next;

  logic [POSITION_BITS-1:0] full_travel_pos, low_target_pos, mid_target_pos, swing_top_pos;
  logic [POSITION_BITS-1:0] aim_target, upper_source, lower_source;
  logic [POSITION_BITS-1:0] position_up, position_down;
  logic [15:0]              upper_brake_calc, lower_brake_calc;
  logic [7:0]               tick_inc;
  logic                     stepped, arrived;

  assign full_travel_pos = POSITION_BITS'(cfg.full_travel);
  assign low_target_pos  = POSITION_BITS'(cfg.low_target);
  assign mid_target_pos  = POSITION_BITS'(cfg.mid_target);
  assign swing_top_pos   = POSITION_BITS'(cfg.swing_top);

  always_comb begin
    case (mode)
      slp_pkg::MODE_RECALL: aim_target = saved_position;
      slp_pkg::MODE_HORIZ:  aim_target = low_target_pos;
      default:              aim_target = mid_target_pos;
    endcase
    case (mode)
      slp_pkg::MODE_CLOSE, slp_pkg::MODE_INIT: upper_source = full_travel_pos;
      slp_pkg::MODE_SWING:                      upper_source = swing_top_pos;
      default:                                  upper_source = aim_target;
    endcase
    case (mode)
      slp_pkg::MODE_RECALL, slp_pkg::MODE_HORIZ, slp_pkg::MODE_UPPER: lower_source = aim_target;
      default: lower_source = '0;
    endcase
  end

  assign upper_brake_calc = 16'(upper_source) - 16'(cfg.slow_period) + 16'(cfg.fast_period);
  assign lower_brake_calc = 16'(lower_source) + 16'(cfg.slow_period) - 16'(cfg.fast_period);
  assign position_up      = position_now + POSITION_BITS'(1);
  assign position_down    = position_now - POSITION_BITS'(1);
  assign tick_inc         = tick_counter + 8'd1;

  always_comb begin
    position_now_next      = position_now;
    target_position_next   = target_position;
    upper_limit_next       = upper_limit;
    lower_limit_next       = lower_limit;
    saved_position_next    = saved_position;
    upper_brake_point_next = upper_brake_point;
    lower_brake_point_next = lower_brake_point;
    direction_up_next      = direction_up;
    enabled_next           = enabled;
    coils_released_next    = coils_released;
    step_period_next       = step_period;
    cruise_period_next     = cruise_period;
    tick_counter_next      = tick_counter;
    pause_counter_next     = pause_counter;
    phase_index_next       = phase_index;
    angle_mode_next        = angle_mode;
    stepped                = 1'b0;
    arrived                = 1'b0;
    if (fire && operation == slp_pkg::OP_COMMAND) begin
      enabled_next = 1'b1;
      case (mode)
        slp_pkg::MODE_STOP: begin
          enabled_next        = 1'b0;
          saved_position_next = position_now;
        end
        slp_pkg::MODE_RECALL, slp_pkg::MODE_HORIZ, slp_pkg::MODE_UPPER: begin
          target_position_next = aim_target;
          angle_mode_next      = mode;
          if (aim_target > position_now) begin
            direction_up_next      = 1'b1;
            upper_limit_next       = upper_source;
            upper_brake_point_next = upper_brake_calc;
          end else if (aim_target < position_now || mode != slp_pkg::MODE_RECALL) begin
            direction_up_next      = 1'b0;
            lower_limit_next       = lower_source;
            lower_brake_point_next = lower_brake_calc;
          end
        end
        slp_pkg::MODE_CLOSE: begin
          target_position_next   = full_travel_pos;
          upper_limit_next       = upper_source;
          upper_brake_point_next = upper_brake_calc;
          lower_limit_next       = '0;
          direction_up_next      = 1'b1;
        end
        slp_pkg::MODE_INIT: begin
          target_position_next   = '0;
          position_now_next      = full_travel_pos;
          upper_limit_next       = upper_source;
          upper_brake_point_next = upper_brake_calc;
          lower_limit_next       = lower_source;
          lower_brake_point_next = lower_brake_calc;
          direction_up_next      = 1'b0;
        end
        slp_pkg::MODE_LOWER: begin
          target_position_next   = '0;
          direction_up_next      = 1'b0;
          lower_limit_next       = lower_source;
          lower_brake_point_next = lower_brake_calc;
          angle_mode_next        = mode;
        end
        slp_pkg::MODE_SWING: begin
          target_position_next   = full_travel_pos;
          upper_limit_next       = upper_source;
          upper_brake_point_next = upper_brake_calc;
          lower_limit_next       = lower_source;
          lower_brake_point_next = lower_brake_calc;
        end
        slp_pkg::MODE_CENTRAL: begin
          target_position_next   = low_target_pos;
          direction_up_next      = 1'b0;
          lower_limit_next       = lower_source;
          lower_brake_point_next = lower_brake_calc;
          angle_mode_next        = mode;
        end
        slp_pkg::MODE_COILS_OFF: begin
          enabled_next        = 1'b0;
          coils_released_next = 1'b1;
        end
        default: begin
          enabled_next = 1'b0;
        end
      endcase
      step_period_next   = cfg.slow_period;
      cruise_period_next = cfg.fast_period;
      tick_counter_next  = '0;
      pause_counter_next = cfg.reverse_pause;
    end else if (fire && enabled) begin
      if (pause_counter != 16'd0) begin
        pause_counter_next = pause_counter - 16'd1;
      end else if (tick_inc < step_period) begin
        tick_counter_next = tick_inc;
      end else begin
        tick_counter_next   = '0;
        stepped             = 1'b1;
        coils_released_next = 1'b0;
        if (direction_up) begin
          phase_index_next  = phase_index - 3'd1;
          position_now_next = position_up;
          if (position_up == target_position) begin
            enabled_next = 1'b0;
            arrived      = 1'b1;
          end else if (position_up == upper_limit) begin
            direction_up_next  = 1'b0;
            pause_counter_next = cfg.reverse_pause;
          end else begin
            step_period_next = slp_pkg::ramp(step_period, cfg.slow_period, cruise_period,
                                             16'(position_up) >= upper_brake_point);
          end
        end else begin
          phase_index_next  = phase_index + 3'd1;
          position_now_next = position_down;
          if (position_down == target_position && angle_mode != slp_pkg::MODE_CENTRAL) begin
            enabled_next = 1'b0;
            arrived      = 1'b1;
          end else if (position_down == lower_limit) begin
            direction_up_next  = 1'b1;
            pause_counter_next = cfg.reverse_pause;
          end else begin
            step_period_next = slp_pkg::ramp(step_period, cfg.slow_period, cruise_period,
                                             16'(position_down) <= lower_brake_point);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_now      <= POSITION_BITS'(slp_pkg::FULL_TRAVEL_RESET);
      target_position   <= '0;
      upper_limit       <= POSITION_BITS'(slp_pkg::FULL_TRAVEL_RESET);
      lower_limit       <= '0;
      saved_position    <= '0;
      upper_brake_point <= '0;
      lower_brake_point <= '0;
      direction_up      <= 1'b0;
      enabled           <= 1'b0;
      coils_released    <= 1'b1;
      step_period       <= slp_pkg::SLOW_PERIOD_RESET;
      cruise_period     <= slp_pkg::FAST_PERIOD_RESET;
      tick_counter      <= '0;
      pause_counter     <= '0;
      phase_index       <= '0;
      angle_mode        <= slp_pkg::MODE_STOP;
    end else begin
      position_now      <= position_now_next;
      target_position   <= target_position_next;
      upper_limit       <= upper_limit_next;
      lower_limit       <= lower_limit_next;
      saved_position    <= saved_position_next;
      upper_brake_point <= upper_brake_point_next;
      lower_brake_point <= lower_brake_point_next;
      direction_up      <= direction_up_next;
      enabled           <= enabled_next;
      coils_released    <= coils_released_next;
      step_period       <= step_period_next;
      cruise_period     <= cruise_period_next;
      tick_counter      <= tick_counter_next;
      pause_counter     <= pause_counter_next;
      phase_index       <= phase_index_next;
      angle_mode        <= angle_mode_next;
    end
  end

  assign position            = position_now_next;
  assign status.coil_pattern = coils_released_next ? 4'h0 : slp_pkg::coil_of(phase_index_next);
  assign status.motor_on     = enabled_next;
  assign status.moving_up    = direction_up_next;
  assign status.stepped      = stepped;
  assign status.arrived      = arrived;
  assign status.pausing      = enabled_next && (pause_counter_next != 16'd0);

endmodule

// ----- hw/rtl/stepper_louver_positioner.sv -----
// Top level of the louver stepper positioner: handshake, configuration and result registers.
//
// Each request is either a 1 ms tick or a mode command, and each produces exactly one
// result that reports the coil drive pattern and the motion state after it. A new request
// can be taken on every clock cycle while no result is stalled. A request is held in the
// input register while the motion update is computed from it, and its result is then loaded
// into the result register. A stalled result holds the next request in the input register.
// The rate is set by the update of the motion state, which every request reads and writes.
// Configuration writes take effect at once and are meant to be made while no request is
// in flight.
module stepper_louver_positioner #(
  parameter int POSITION_BITS = slp_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               request_valid,
  output logic                               request_stall,
  input  logic                               operation,
  input  logic [3:0]                         mode,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [3:0]                         coil_pattern,
  output logic [POSITION_BITS-1:0]           position,
  output logic                               motor_on,
  output logic                               moving_up,
  output logic                               stepped,
  output logic                               arrived,
  output logic                               pausing,
  input  logic                               cfg_write,
  input  logic [slp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [slp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  slp_pkg::slp_cfg_t        cfg;
  slp_pkg::slp_status_t     status;
  logic [POSITION_BITS-1:0] engine_position;
  logic                     held_valid;
  logic                     held_operation;
  logic [3:0]               held_mode;
  logic                     result_free;
  logic                     advance;
  logic                     accept;

  assign result_free   = !result_valid || !result_stall;
  assign advance       = held_valid && result_free;
  assign request_stall = held_valid && !result_free;
  assign accept        = request_valid && !request_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_target    <= slp_pkg::LOW_TARGET_RESET;
      cfg.mid_target    <= slp_pkg::MID_TARGET_RESET;
      cfg.swing_top     <= slp_pkg::SWING_TOP_RESET;
      cfg.full_travel   <= slp_pkg::FULL_TRAVEL_RESET;
      cfg.fast_period   <= slp_pkg::FAST_PERIOD_RESET;
      cfg.slow_period   <= slp_pkg::SLOW_PERIOD_RESET;
      cfg.reverse_pause <= slp_pkg::REVERSE_PAUSE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        slp_pkg::REG_LOW_TARGET:    cfg.low_target    <= cfg_data[11:0];
        slp_pkg::REG_MID_TARGET:    cfg.mid_target    <= cfg_data[11:0];
        slp_pkg::REG_SWING_TOP:     cfg.swing_top     <= cfg_data[11:0];
        slp_pkg::REG_FULL_TRAVEL:   cfg.full_travel   <= cfg_data[11:0];
        slp_pkg::REG_FAST_PERIOD:   cfg.fast_period   <= cfg_data[7:0];
        slp_pkg::REG_SLOW_PERIOD:   cfg.slow_period   <= cfg_data[7:0];
        slp_pkg::REG_REVERSE_PAUSE: cfg.reverse_pause <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_operation <= operation;
      held_mode      <= mode;
    end
  end

  slp_engine #(
    .POSITION_BITS(POSITION_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .operation(held_operation),
    .mode     (held_mode),
    .cfg      (cfg),
    .position (engine_position),
    .status   (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_free) begin
      result_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      coil_pattern <= status.coil_pattern;
      position     <= engine_position;
      motor_on     <= status.motor_on;
      moving_up    <= status.moving_up;
      stepped      <= status.stepped;
      arrived      <= status.arrived;
      pausing      <= status.pausing;
    end
  end

`ifndef SYNTHESIS
  a_arrived_after_step: assert property (@(posedge clk) disable iff (rst)
    result_valid && arrived |-> stepped && !motor_on)
    else $error("arrival reported without a step or with the motor still on");

  a_pause_needs_motor: assert property (@(posedge clk) disable iff (rst)
    result_valid && pausing |-> motor_on)
    else $error("pause reported while the motor is off");

  a_step_drives_coils: assert property (@(posedge clk) disable iff (rst)
    result_valid && stepped |-> coil_pattern != 4'h0)
    else $error("step reported with the coils released");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    request_stall |-> held_valid && result_valid && result_stall)
    else $error("request stalled while the pipeline has room");

  a_result_follows_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("a request left the input register without producing a result");
`endif

endmodule
